@@ hw/rtl/acfr_pkg.sv @@
package acfr_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRC
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD,
    KIND_GOOD,
    KIND_CRC_ERR
  } kind_t;

  localparam byte_t       START_MARK = 8'h23;
  localparam logic [6:0]  MAX_LEN    = 7'd99;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  typedef struct packed {
    byte_t rx_byte;
  } rx_beat_t;

  typedef struct packed {
    kind_t             kind;
    byte_t             payload_byte;
    logic signed [7:0] frame_address;
    logic [6:0]        payload_length;
    logic [15:0]       computed_crc;
    logic [15:0]       received_crc;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } res_beat_t;

  function automatic logic is_ws(input byte_t c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input byte_t c);
    return (c >= 8'h30 && c <= 8'h39);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input byte_t c);
    logic [4:0] r;
    r = '0;
    if (is_digit(c)) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // atoi on a two-character string
  function automatic logic signed [7:0] dec2(input byte_t a, input byte_t b);
    logic [6:0] mag;
    logic       neg;
    mag = '0;
    neg = 1'b0;
    if (is_ws(a)) begin
      if (is_digit(b)) mag = {3'b000, b[3:0]};
    end else if (a == 8'h2B || a == 8'h2D) begin
      neg = (a == 8'h2D);
      if (is_digit(b)) mag = {3'b000, b[3:0]};
    end else if (is_digit(a) && is_digit(b)) begin
      mag = 7'(a[3:0] * 10 + b[3:0]);
    end else if (is_digit(a)) begin
      mag = {3'b000, a[3:0]};
    end
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // strtol base 16 on four characters, s[0] first
  function automatic logic [15:0] hex4(input logic [3:0][7:0] s);
    logic [2:0]  i;
    logic        stop;
    logic        neg;
    logic [15:0] v;
    logic [4:0]  h;
    i    = '0;
    stop = 1'b0;
    neg  = 1'b0;
    v    = '0;
    for (int k = 0; k < 4; k++) begin
      if (!stop && is_ws(s[k])) i = 3'(k + 1);
      else stop = 1'b1;
    end
    if (i < 3'd4 && (s[i[1:0]] == 8'h2B || s[i[1:0]] == 8'h2D)) begin
      neg = (s[i[1:0]] == 8'h2D);
      i   = i + 3'd1;
    end
    if (i < 3'd3 && s[i[1:0]] == 8'h30 &&
        (s[2'(i + 3'd1)] == 8'h78 || s[2'(i + 3'd1)] == 8'h58)) begin
      i = i + 3'd2;
    end
    stop = 1'b0;
    for (int k = 0; k < 4; k++) begin
      h = hex_val(s[k]);
      if (3'(k) >= i && !stop) begin
        if (h[4]) v = {v[11:0], h[3:0]};
        else stop = 1'b1;
      end
    end
    return neg ? 16'(-v) : v;
  endfunction

  function automatic logic [15:0] crc_upd(input logic [15:0] crc, input byte_t b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/acfr_chan_if.sv @@
interface acfr_chan_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/ascii_crc16_frame_receiver_top.sv @@
// ASCII frame receiver with CRC-16/MODBUS check.
// in_ch carries one received byte per beat. A frame is '#', two address
// characters, two length characters (decimal, 1..99), the payload, then four
// hex CRC characters. Bytes outside a frame give no result.
// out_ch gives one beat per payload byte (kind payload) and one verdict beat
// per frame (good or crc error) carrying computed and received CRC. Address
// and length of the current frame ride along on every beat.
// A byte waits in the input register; any result it gives waits in the
// result register. Throughput: one byte per cycle while out_ch is not
// stalled, set by the single input register and the single result register
// around the per-byte parse and CRC logic. A stalled out_ch holds its beat;
// the input register still takes one more byte, then in_ch.ready drops
// until the result is taken. Synchronous reset clears both registers' valid
// flags and returns the parser to hunting for '#' with the CRC at 0xFFFF.
module ascii_crc16_frame_receiver_top
  import acfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  acfr_chan_if.sink   in_ch,
  acfr_chan_if.source out_ch
);

  res_beat_t beat;
  logic      slot_free;

  acfr_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .slot_free (slot_free),
    .beat      (beat)
  );

  acfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule

@@ hw/rtl/acfr_step.sv @@
module acfr_step
  import acfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  acfr_chan_if.sink    in_ch,
  input  logic         slot_free,
  output res_beat_t    beat
);

  logic        s1_valid_r;
  byte_t       s1_byte_r;
  logic        fire;

  phase_t      phase_r, phase_nxt;
  byte_t       hb_r [4];
  byte_t       hb_nxt [4];
  logic [1:0]  hc_r, hc_nxt;
  logic [6:0]  bc_r, bc_nxt;
  logic [15:0] crc_r, crc_nxt;
  byte_t       cc_r [3];
  byte_t       cc_nxt [3];

  byte_t             hb_wr [4];
  logic signed [7:0] len_new;
  logic              len_ok;
  logic              mark_found;
  logic [1:0]        mark_pos;
  logic signed [7:0] len_cur;
  logic [6:0]        bc_inc;
  logic              pay_last;
  logic [15:0]       rx_crc;

  assign fire        = s1_valid_r && slot_free;
  assign in_ch.ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) s1_byte_r <= in_ch.payload.rx_byte;
  end

  // header with the current byte written in
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hb_wr[i] = (hc_r == 2'(i)) ? s1_byte_r : hb_r[i];
    end
  end

  assign len_new = dec2(hb_wr[2], hb_wr[3]);
  assign len_ok  = (len_new >= 8'sd1) && (len_new <= $signed({1'b0, MAX_LEN}));

  always_comb begin
    mark_found = 1'b0;
    mark_pos   = '0;
    for (int k = 3; k >= 0; k--) begin
      if (hb_wr[k] == START_MARK) begin
        mark_found = 1'b1;
        mark_pos   = 2'(k);
      end
    end
  end

  assign len_cur  = dec2(hb_r[2], hb_r[3]);
  assign bc_inc   = bc_r + 7'd1;
  assign pay_last = bc_inc >= len_cur[6:0];
  assign rx_crc   = hex4({s1_byte_r, cc_r[2], cc_r[1], cc_r[0]});

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (s1_byte_r == START_MARK) phase_nxt = PH_HEADER;
        end
        PH_HEADER: begin
          if (hc_r == 2'd3) begin
            if (len_ok) phase_nxt = PH_PAYLOAD;
            else if (!mark_found) phase_nxt = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          if (pay_last) phase_nxt = PH_CRC;
        end
        PH_CRC: begin
          if (bc_r == 7'd3) phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    hc_nxt  = hc_r;
    bc_nxt  = bc_r;
    crc_nxt = crc_r;
    hb_nxt  = hb_r;
    cc_nxt  = cc_r;
    beat    = '0;
    beat.res.frame_address  = dec2(hb_r[0], hb_r[1]);
    beat.res.payload_length = len_cur[6:0];
    if (fire) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (s1_byte_r == START_MARK) hc_nxt = '0;
        end
        PH_HEADER: begin
          hb_nxt = hb_wr;
          if (hc_r != 2'd3) begin
            hc_nxt = hc_r + 2'd1;
          end else if (len_ok) begin
            bc_nxt  = '0;
            crc_nxt = CRC_INIT;
          end else if (mark_found) begin
            // keep the bytes after the first mark as the new header start
            for (int j = 0; j < 3; j++) begin
              if (j + int'(mark_pos) + 1 < 4) hb_nxt[j] = hb_wr[2'(j + int'(mark_pos) + 1)];
            end
            hc_nxt = 2'd3 - mark_pos;
          end else begin
            hc_nxt = '0;
          end
        end
        PH_PAYLOAD: begin
          crc_nxt                = crc_upd(crc_r, s1_byte_r);
          bc_nxt                 = pay_last ? 7'd0 : bc_inc;
          beat.valid             = 1'b1;
          beat.res.kind          = KIND_PAYLOAD;
          beat.res.payload_byte  = s1_byte_r;
        end
        PH_CRC: begin
          if (bc_r < 7'd3) begin
            cc_nxt[bc_r[1:0]] = s1_byte_r;
            bc_nxt            = bc_inc;
          end else begin
            beat.valid            = 1'b1;
            beat.res.kind         = (rx_crc == crc_r) ? KIND_GOOD : KIND_CRC_ERR;
            beat.res.computed_crc = crc_r;
            beat.res.received_crc = rx_crc;
            hc_nxt                = '0;
            bc_nxt                = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      hc_r    <= '0;
      bc_r    <= '0;
      crc_r   <= CRC_INIT;
    end else begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      bc_r    <= bc_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hb_r <= hb_nxt;
    cc_r <= cc_nxt;
  end

endmodule

@@ hw/rtl/acfr_out_stage.sv @@
module acfr_out_stage
  import acfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  res_beat_t    beat,
  output logic         slot_free,
  acfr_chan_if.source  out_ch
);

  logic    valid_r;
  result_t res_r;

  assign slot_free      = !valid_r || out_ch.ready;
  assign out_ch.valid   = valid_r;
  assign out_ch.payload = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && beat.valid) res_r <= beat.res;
  end

endmodule

@@ hw/rtl/acfr_checker.sv @@
module acfr_checker
  import acfr_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_res
);

  // a waiting beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.kind == KIND_PAYLOAD |->
      out_res.computed_crc == 16'h0000 && out_res.received_crc == 16'h0000 &&
      out_res.payload_length >= 7'd1 && out_res.payload_length <= MAX_LEN)
    else $error("payload beat fields out of range");

  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.kind != KIND_PAYLOAD |->
      out_res.payload_byte == 8'h00 &&
      ((out_res.kind == KIND_GOOD && out_res.computed_crc == out_res.received_crc) ||
       (out_res.kind == KIND_CRC_ERR && out_res.computed_crc != out_res.received_crc)))
    else $error("verdict does not match the CRC compare");

endmodule

bind ascii_crc16_frame_receiver_top acfr_checker u_acfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_res   (out_ch.payload)
);

@@ test/acfr_frame_checker.sv @@
`timescale 1ns / 100ps

module acfr_frame_checker
  import acfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_ready,
  input  byte_t   in_byte,
  input  logic    out_valid,
  input  logic    out_ready,
  input  result_t out_res,
  output int      mismatches,
  output int      pending,
  output int      payload_beats,
  output int      good_frames,
  output int      bad_frames
);

  phase_t      phase;
  byte_t       hdr [4];
  int          hdr_cnt;
  int          cnt;
  logic [15:0] crc;
  byte_t       crc_txt [3];
  result_t     frame_beats_q [$];
  int          errs;
  int          n_payload;
  int          n_good;
  int          n_bad;

  function automatic bit is_space(input byte_t c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic int hex_digit(input byte_t c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // two-char decimal field, C atoi rules
  function automatic int atoi2(input byte_t a, input byte_t b);
    byte_t s [2];
    int    i;
    int    v;
    bit    neg;
    s[0] = a;
    s[1] = b;
    i    = 0;
    v    = 0;
    neg  = 1'b0;
    while (i < 2 && is_space(s[i])) i++;
    if (i < 2 && (s[i] == "+" || s[i] == "-")) begin
      neg = (s[i] == "-");
      i++;
    end
    while (i < 2 && s[i] >= "0" && s[i] <= "9") begin
      v = v * 10 + (s[i] - "0");
      i++;
    end
    return neg ? -v : v;
  endfunction

  // four-char hex field, strtol base 16 rules, mod 2^16
  function automatic logic [15:0] strtol16(input byte_t s [4]);
    int          i;
    logic [15:0] v;
    bit          neg;
    i   = 0;
    v   = '0;
    neg = 1'b0;
    while (i < 4 && is_space(s[i])) i++;
    if (i < 4 && (s[i] == "+" || s[i] == "-")) begin
      neg = (s[i] == "-");
      i++;
    end
    if (i + 1 < 4 && s[i] == "0" && (s[i + 1] == "x" || s[i + 1] == "X")) i += 2;
    while (i < 4 && hex_digit(s[i]) >= 0) begin
      v = {v[11:0], 4'(hex_digit(s[i]))};
      i++;
    end
    return neg ? 16'(-v) : v;
  endfunction

  function automatic logic [15:0] crc_next(input logic [15:0] c_in, input byte_t b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  task automatic queue_beat(input kind_t k, input byte_t pb, input logic [15:0] cc,
                            input logic [15:0] rc);
    result_t r;
    r.kind           = k;
    r.payload_byte   = pb;
    r.frame_address  = 8'(atoi2(hdr[0], hdr[1]));
    r.payload_length = 7'(atoi2(hdr[2], hdr[3]));
    r.computed_crc   = cc;
    r.received_crc   = rc;
    frame_beats_q.push_back(r);
  endtask

  task automatic parse_byte(input byte_t b);
    int          len;
    int          k;
    int          j;
    byte_t       s [4];
    logic [15:0] rc;
    case (phase)
      PH_HUNT: begin
        if (b == START_MARK) begin
          phase   = PH_HEADER;
          hdr_cnt = 0;
        end
      end
      PH_HEADER: begin
        hdr[hdr_cnt] = b;
        hdr_cnt++;
        if (hdr_cnt == 4) begin
          len = atoi2(hdr[2], hdr[3]);
          if (len >= 1 && len <= MAX_LEN) begin
            phase = PH_PAYLOAD;
            cnt   = 0;
            crc   = CRC_INIT;
          end else begin
            // drop the mark, restart from the first '#' inside the header
            k = 0;
            while (k < 4 && hdr[k] != START_MARK) k++;
            if (k < 4) begin
              for (j = 0; j + k + 1 < 4; j++) hdr[j] = hdr[j + k + 1];
              hdr_cnt = 3 - k;
            end else begin
              hdr_cnt = 0;
              phase   = PH_HUNT;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        len = atoi2(hdr[2], hdr[3]);
        crc = crc_next(crc, b);
        cnt = (cnt + 1) & 127;
        queue_beat(KIND_PAYLOAD, b, '0, '0);
        if (cnt >= len) begin
          phase = PH_CRC;
          cnt   = 0;
        end
      end
      default: begin
        if (cnt < 3) begin
          crc_txt[cnt] = b;
          cnt++;
        end else begin
          s[0] = crc_txt[0];
          s[1] = crc_txt[1];
          s[2] = crc_txt[2];
          s[3] = b;
          rc   = strtol16(s);
          if (rc == crc) queue_beat(KIND_GOOD, '0, crc, rc);
          else queue_beat(KIND_CRC_ERR, '0, crc, rc);
          phase   = PH_HUNT;
          hdr_cnt = 0;
          cnt     = 0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    string   diffs;
    if (!rst_n) begin
      phase   = PH_HUNT;
      hdr_cnt = 0;
      cnt     = 0;
      crc     = CRC_INIT;
      for (int k = 0; k < 4; k++) hdr[k] = '0;
      frame_beats_q.delete();
      errs      = 0;
      n_payload = 0;
      n_good    = 0;
      n_bad     = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_beats_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got kind=%0d byte=%02h addr=%0d len=%0d crc=%04h/%04h",
                   $time, out_res.kind, out_res.payload_byte, out_res.frame_address,
                   out_res.payload_length, out_res.computed_crc, out_res.received_crc);
          errs++;
        end else begin
          want  = frame_beats_q.pop_front();
          diffs = "";
          if (out_res.kind !== want.kind)
            diffs = {diffs, $sformatf(" kind exp %0d got %0d", want.kind, out_res.kind)};
          if (out_res.payload_byte !== want.payload_byte)
            diffs = {diffs, $sformatf(" payload_byte exp %02h got %02h",
                                      want.payload_byte, out_res.payload_byte)};
          if (out_res.frame_address !== want.frame_address)
            diffs = {diffs, $sformatf(" frame_address exp %0d got %0d",
                                      want.frame_address, out_res.frame_address)};
          if (out_res.payload_length !== want.payload_length)
            diffs = {diffs, $sformatf(" payload_length exp %0d got %0d",
                                      want.payload_length, out_res.payload_length)};
          if (out_res.computed_crc !== want.computed_crc)
            diffs = {diffs, $sformatf(" computed_crc exp %04h got %04h",
                                      want.computed_crc, out_res.computed_crc)};
          if (out_res.received_crc !== want.received_crc)
            diffs = {diffs, $sformatf(" received_crc exp %04h got %04h",
                                      want.received_crc, out_res.received_crc)};
          if (diffs != "") begin
            $display("%0t: beat mismatch:%s", $time, diffs);
            errs++;
          end else if (want.kind == KIND_PAYLOAD) begin
            n_payload++;
          end else if (want.kind == KIND_GOOD) begin
            n_good++;
          end else begin
            n_bad++;
          end
        end
      end
      if (in_valid && in_ready) parse_byte(in_byte);
    end
    mismatches    <= errs;
    pending       <= frame_beats_q.size();
    payload_beats <= n_payload;
    good_frames   <= n_good;
    bad_frames    <= n_bad;
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import acfr_pkg::*;

  localparam int RANDOM_BYTES = 280;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum int {
    CRC_UPPER,
    CRC_LOWER,
    CRC_ALT,
    CRC_JUNK,
    CRC_FLIP,
    CRC_GIVEN
  } crc_style_t;

  logic  clk = 1'b0;
  logic  rst_n;
  int    cycles = 0;
  bit    calm = 1'b0;
  byte_t rx_stream [$];
  int    directed_len;
  int    mismatches;
  int    pending;
  int    payload_beats;
  int    good_frames;
  int    bad_frames;

  acfr_chan_if #(.payload_t(rx_beat_t)) in_ch ();
  acfr_chan_if #(.payload_t(result_t))  out_ch ();

  ascii_crc16_frame_receiver_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  acfr_frame_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_byte       (in_ch.payload.rx_byte),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_res       (out_ch.payload),
    .mismatches    (mismatches),
    .pending       (pending),
    .payload_beats (payload_beats),
    .good_frames   (good_frames),
    .bad_frames    (bad_frames)
  );

  always #2 clk = ~clk;

  // calm stretches: no gaps and no stalls on either side
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if ($urandom_range(0, 59) == 0) calm <= ~calm;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [15:0] modbus_crc(input logic [15:0] c_in, input byte_t b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic put(input byte_t b);
    rx_stream.push_back(b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_addr();
    int d;
    d = $urandom_range(0, 9);
    case ($urandom_range(0, 5))
      0: put_text($sformatf("%02d", $urandom_range(0, 99)));
      1: put_text($sformatf(" %0d", d));
      2: put_text($sformatf("-%0d", d));
      3: put_text($sformatf("+%0d", d));
      4: put_text($sformatf("%0d:", d));
      default: begin
        put(byte_t'($urandom_range(0, 255)));
        put(byte_t'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // length text that decodes to n (1..99)
  task automatic put_len(input int n);
    if (n >= 10) begin
      put_text($sformatf("%02d", n));
    end else begin
      case ($urandom_range(0, 4))
        0: put_text($sformatf("0%0d", n));
        1: put_text($sformatf(" %0d", n));
        2: put_text($sformatf("+%0d", n));
        3: begin
          put_text($sformatf("%0d", n));
          put($urandom_range(0, 1) ? START_MARK : 8'h3B);
        end
        default: begin
          put(byte_t'(8'h09 + $urandom_range(0, 4)));
          put_text($sformatf("%0d", n));
        end
      endcase
    end
  endtask

  task automatic add_body(input int n, input crc_style_t style, input string given);
    logic [15:0] c;
    byte_t       b;
    string       junk;
    junk = "0123456789abcdefABCDEFxX +-\t#g";
    c    = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(0, 9) == 0) ? START_MARK : byte_t'($urandom_range(0, 255));
      put(b);
      c = modbus_crc(c, b);
    end
    case (style)
      CRC_UPPER: put_text($sformatf("%04X", c));
      CRC_LOWER: put_text($sformatf("%04x", c));
      CRC_ALT: begin
        // prefix, sign and padding forms that still parse to the same value
        if (c < 16'h0100) put_text($sformatf("0x%02x", c));
        else if (c < 16'h1000) put_text($sformatf("%s%03X", $urandom_range(0, 1) ? " " : "+", c));
        else if (c > 16'hF000) put_text($sformatf("-%03X", 17'h10000 - c));
        else put_text($sformatf("%04X", c));
      end
      CRC_JUNK: repeat (4) put(junk[$urandom_range(0, junk.len() - 1)]);
      CRC_FLIP: put_text($sformatf("%04X", c ^ (16'h0001 << $urandom_range(0, 15))));
      default: put_text(given);
    endcase
  endtask

  task automatic add_frame(input int n, input crc_style_t style);
    put(START_MARK);
    put_addr();
    put_len(n);
    add_body(n, style, "");
  endtask

  task automatic send_byte(input byte_t b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // result side: a fresh stall per beat
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    int    r;
    int    n;
    string hdr_chars;
    hdr_chars     = "#0-+ 9x";
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    rst_n         <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // bytes outside a frame are dropped
    put(8'h00);
    put(8'hFF);
    put_text("A 5");
    put_text("#0105");
    add_body(5, CRC_UPPER, "");
    // lowest address, longest payload
    put_text("#-999");
    add_body(99, CRC_LOWER, "");
    put_text("#99 1");
    add_body(1, CRC_ALT, "");
    put_text("#+31x");
    add_body(1, CRC_JUNK, "");
    // zero and negative length go back to hunting
    put_text("#ab00");
    put_text("#12-5");
    // bad length with a mark inside the header: resync on it
    put_text("#00#1205");
    add_body(5, CRC_UPPER, "");
    put_text("#0702");
    add_body(2, CRC_GIVEN, "zzzz");
    put_text("#0802");
    add_body(2, CRC_GIVEN, "-0x1");
    put_text("#09 3");
    add_body(3, CRC_GIVEN, " \t+F");
    put_text("#1003");
    add_body(3, CRC_FLIP, "");
    directed_len = rx_stream.size();

    while (rx_stream.size() < directed_len + RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) put(byte_t'($urandom_range(0, 255)));
      end else if (r < 18) begin
        // broken header, often a bad length, sometimes with a mark inside
        put(START_MARK);
        repeat (4) put(hdr_chars[$urandom_range(0, hdr_chars.len() - 1)]);
      end else begin
        n = ($urandom_range(0, 29) == 0) ? $urandom_range(50, 99) : $urandom_range(1, 8);
        add_frame(n, crc_style_t'($urandom_range(0, 4)));
      end
    end

    foreach (rx_stream[i]) send_byte(rx_stream[i]);
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("Fed %0d bytes (%0d directed) with random gaps and stalls.",
             rx_stream.size(), directed_len);
    $display("Checked %0d payload beats, %0d good frames, %0d crc error frames.",
             payload_beats, good_frames, bad_frames);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
